@@ sv/fchc_pkg.sv @@
// ----------------------------------------------------------------------------
// fchc_pkg
// Shared types and constants for the fan curve controller with hysteresis.
// ----------------------------------------------------------------------------
package fchc_pkg;

   localparam int TEMP_W  = 16;   // signed Q8.8
   localparam int DUTY_W  = 8;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int PROD_W  = TEMP_W + DUTY_W;

   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

   // register indexes (byte address / 4)
   typedef enum logic [2:0] {
      REG_NORMAL_THRESH = 3'd0,
      REG_NORMAL_TEMPS  = 3'd1,
      REG_NORMAL_DUTY   = 3'd2,
      REG_BENCH_THRESH  = 3'd3,
      REG_BENCH_TEMPS   = 3'd4,
      REG_BENCH_DUTY    = 3'd5
   } reg_index_type;

   localparam logic [31:0] RST_THRESH = 32'h2800_2300;  // on 40.0, off 35.0
   localparam logic [31:0] RST_TEMPS  = 32'h1E00_3C00;  // 30.0 .. 60.0
   localparam logic [15:0] RST_DUTY   = 16'h50FF;       // 80 .. 255

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CALC,
      ST_DONE
   } state_type;

   // operands for the serial multiply/divide: q = (x * m) / den, x < den
   typedef struct packed {
      logic              start;
      logic [TEMP_W-1:0] x;
      logic [DUTY_W-1:0] m;
      logic [TEMP_W-1:0] den;
   } muldiv_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DUTY_W-1:0] q;
   } muldiv_stat_type;

endpackage

@@ sv/fchc_stream_if.sv @@
// ----------------------------------------------------------------------------
// fchc_req_if / fchc_rsp_if
// Valid/ready channels for temperature samples and duty results.
// ----------------------------------------------------------------------------
interface fchc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [fchc_pkg::TEMP_W-1:0]  temperature;
   logic                                benchmark_mode;

   modport source (output valid, output temperature, output benchmark_mode, input ready);
   modport sink   (input valid, input temperature, input benchmark_mode, output ready);
endinterface

interface fchc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [fchc_pkg::DUTY_W-1:0]         duty;
   logic                                fan_on;

   modport source (output valid, output duty, output fan_on, input ready);
   modport sink   (input valid, input duty, input fan_on, output ready);
endinterface

@@ sv/fchc_muldiv.sv @@
// ----------------------------------------------------------------------------
// fchc_muldiv
// Bit-serial q = (x * m) / den: 8 shift-add multiply steps, then 8 restoring
// divide steps on the same register. Requires x < den, so q fits in 8 bits.
// ----------------------------------------------------------------------------
module fchc_muldiv (
   input  logic                     clock,
   input  logic                     reset,
   input  fchc_pkg::muldiv_req_type req,
   output fchc_pkg::muldiv_stat_type stat
);
   import fchc_pkg::*;

   localparam int CNT_W = $clog2(2 * DUTY_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [DUTY_W-1:0] m_ff, m_in;
   logic [TEMP_W-1:0] x_ff, x_in;
   logic [TEMP_W-1:0] den_ff, den_in;

   logic              div_phase;
   logic [TEMP_W:0]   top;
   logic [TEMP_W+1:0] diff;

   assign div_phase = cnt_ff[CNT_W-1];
   // partial remainder with the next dividend bit shifted in
   assign top  = {acc_ff[PROD_W-1:DUTY_W], acc_ff[DUTY_W-1]};
   assign diff = {1'b0, top} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      m_in    = m_ff;
      x_in    = x_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         m_in    = req.m;
         x_in    = req.x;
         den_in  = req.den;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (!div_phase) begin
            // MSB-first shift-add
            acc_in = {acc_ff[PROD_W-2:0], 1'b0} +
                     (m_ff[DUTY_W-1] ? {{DUTY_W{1'b0}}, x_ff} : '0);
            m_in   = {m_ff[DUTY_W-2:0], 1'b0};
         end else if (!diff[TEMP_W+1]) begin
            acc_in = {diff[TEMP_W-1:0], acc_ff[DUTY_W-2:0], 1'b1};
         end else begin
            acc_in = {top[TEMP_W-1:0], acc_ff[DUTY_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(2 * DUTY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      m_ff   <= m_in;
      x_ff   <= x_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.q    = acc_ff[DUTY_W-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff && !done_ff)
      else $error("muldiv restarted while in use");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("muldiv done without a preceding run");

   a_div_quot_fits: assert property (@(posedge clock) disable iff (reset)
      busy_ff && div_phase && cnt_ff[CNT_W-2:0] == '0 |->
         acc_ff[PROD_W-1:DUTY_W] < den_ff)
      else $error("muldiv dividend out of range for 8-bit quotient");

endmodule

@@ sv/fan_curve_hysteresis_control.sv @@
// ----------------------------------------------------------------------------
// fan_curve_hysteresis_control
// Each temperature beat yields one duty beat. An on/off flag gives
// hysteresis: an off fan starts when the sample is above the on threshold,
// a running fan stops when it is below the off threshold. A running fan
// follows a piecewise-linear curve between the low and high curve points,
// the offset of an interpolated value from the low point truncated toward
// zero. The mode bit picks the normal or benchmark register set. A sample
// passes idle, eval and done when the duty is 0 or at a curve end, and
// idle, eval, calc and done when interpolated; in calc the bit-serial
// multiply/divide unit gives one bit per cycle over 8 multiply and 8
// divide steps. A new sample is taken while a finished result still waits on the response channel.
// ----------------------------------------------------------------------------
module fan_curve_hysteresis_control (
   input  logic                             clock,
   input  logic                             reset,
   fchc_req_if.sink                         req_bus,
   fchc_rsp_if.source                       rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fchc_pkg::ADDR_W-1:0]      paddr,
   input  logic [fchc_pkg::DATA_W-1:0]      pwdata,
   output logic [fchc_pkg::DATA_W-1:0]      prdata,
   output logic                             pready
);
   import fchc_pkg::*;

   // configuration registers
   logic [31:0] n_thresh_ff, n_temps_ff, b_thresh_ff, b_temps_ff;
   logic [15:0] n_duty_ff, b_duty_ff;
   logic        wr_en;
   reg_index_type wr_idx;

   // item state
   state_type          state_ff, state_in;
   logic               running_ff, running_in;
   logic signed [TEMP_W-1:0] t_ff;
   logic               mode_ff;
   logic [DUTY_W-1:0]  duty_ff, duty_in;
   logic [DUTY_W-1:0]  plow_ff, plow_in;
   logic               neg_ff, neg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]  rsp_duty_ff;
   logic               rsp_on_ff;
   logic               rsp_load;

   muldiv_req_type     md_req;
   muldiv_stat_type    md_stat;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign wr_idx = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_thresh_ff <= RST_THRESH;
         n_temps_ff  <= RST_TEMPS;
         n_duty_ff   <= RST_DUTY;
         b_thresh_ff <= RST_THRESH;
         b_temps_ff  <= RST_TEMPS;
         b_duty_ff   <= RST_DUTY;
      end else if (wr_en) begin
         case (wr_idx)
            REG_NORMAL_THRESH: n_thresh_ff <= pwdata;
            REG_NORMAL_TEMPS:  n_temps_ff  <= pwdata;
            REG_NORMAL_DUTY:   n_duty_ff   <= pwdata[15:0];
            REG_BENCH_THRESH:  b_thresh_ff <= pwdata;
            REG_BENCH_TEMPS:   b_temps_ff  <= pwdata;
            REG_BENCH_DUTY:    b_duty_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (wr_idx)
         REG_NORMAL_THRESH: prdata = n_thresh_ff;
         REG_NORMAL_TEMPS:  prdata = n_temps_ff;
         REG_NORMAL_DUTY:   prdata = {16'h0000, n_duty_ff};
         REG_BENCH_THRESH:  prdata = b_thresh_ff;
         REG_BENCH_TEMPS:   prdata = b_temps_ff;
         REG_BENCH_DUTY:    prdata = {16'h0000, b_duty_ff};
         default:           prdata = '0;
      endcase
   end

   // ---------------- evaluation ----------------
   logic [31:0] sel_thresh, sel_temps;
   logic [15:0] sel_duty;
   logic signed [TEMP_W-1:0] on_t, off_t, tlow, thigh;
   logic [DUTY_W-1:0] plow, phigh;
   logic        run_next;
   logic        need_div;
   logic signed [TEMP_W:0] x_wide, den_wide;
   logic [DUTY_W:0] dp, dp_neg;
   logic [DUTY_W+1:0] sum;
   logic [DUTY_W-1:0] final_duty;

   assign sel_thresh = mode_ff ? b_thresh_ff : n_thresh_ff;
   assign sel_temps  = mode_ff ? b_temps_ff  : n_temps_ff;
   assign sel_duty   = mode_ff ? b_duty_ff   : n_duty_ff;
   assign on_t  = signed'(sel_thresh[31:16]);
   assign off_t = signed'(sel_thresh[15:0]);
   assign tlow  = signed'(sel_temps[31:16]);
   assign thigh = signed'(sel_temps[15:0]);
   assign plow  = sel_duty[15:8];
   assign phigh = sel_duty[7:0];

   always_comb begin
      if (!running_ff) run_next = (t_ff > on_t);
      else             run_next = !(t_ff < off_t);
   end

   assign need_div = run_next && (t_ff > tlow) && (t_ff < thigh);
   assign x_wide   = {t_ff[TEMP_W-1], t_ff} - {tlow[TEMP_W-1], tlow};
   assign den_wide = {thigh[TEMP_W-1], thigh} - {tlow[TEMP_W-1], tlow};
   assign dp       = {1'b0, phigh} - {1'b0, plow};
   assign dp_neg   = ~dp + 1'b1;

   assign md_req.start = (state_ff == ST_EVAL) && need_div;
   assign md_req.x     = x_wide[TEMP_W-1:0];
   assign md_req.den   = den_wide[TEMP_W-1:0];
   assign md_req.m     = dp[DUTY_W] ? dp_neg[DUTY_W-1:0] : dp[DUTY_W-1:0];

   // plow +/- quotient, clamped
   assign sum = neg_ff ? ({2'b00, plow_ff} - {2'b00, md_stat.q})
                       : ({2'b00, plow_ff} + {2'b00, md_stat.q});
   always_comb begin
      if (sum[DUTY_W+1])    final_duty = '0;
      else if (sum[DUTY_W]) final_duty = DUTY_MAX;
      else                  final_duty = sum[DUTY_W-1:0];
   end

   fchc_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .stat  (md_stat)
   );

   // ---------------- control ----------------
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_bus.valid) state_in = ST_EVAL;
         ST_EVAL: state_in = need_div ? ST_CALC : ST_DONE;
         ST_CALC: if (md_stat.done) state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      running_in   = running_ff;
      duty_in      = duty_ff;
      plow_in      = plow_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
      case (state_ff)
         ST_EVAL: begin
            running_in = run_next;
            plow_in    = plow;
            neg_in     = dp[DUTY_W];
            if (!run_next)          duty_in = '0;
            else if (t_ff <= tlow)  duty_in = plow;
            else                    duty_in = phigh;
         end
         ST_CALC: if (md_stat.done) duty_in = final_duty;
         default: ;
      endcase
   end

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      duty_ff <= duty_in;
      plow_ff <= plow_in;
      neg_ff  <= neg_in;
      if (req_bus.valid && req_bus.ready) begin
         t_ff    <= req_bus.temperature;
         mode_ff <= req_bus.benchmark_mode;
      end
      if (rsp_load) begin
         rsp_duty_ff <= duty_ff;
         rsp_on_ff   <= running_ff;
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.duty   = rsp_duty_ff;
   assign rsp_bus.fan_on = rsp_on_ff;

   a_ready_unit_free: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !md_stat.busy && !md_stat.done)
      else $error("input ready while divider in use");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      md_stat.done |-> state_ff == ST_CALC)
      else $error("divider result outside calc state");

   a_off_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.fan_on |-> rsp_bus.duty == '0)
      else $error("fan off with nonzero duty");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> state_ff == ST_EVAL)
      else $error("accepted beat not evaluated");

endmodule
